// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/tpag_pkg.sv
// ----------------------------------------------------------------------------
// tpag_pkg
// Constants, types and helpers of the permute address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;
	localparam int MAX_AXES   = 4;
	localparam int HW_AXES    = 4;
	localparam int INDEX_BITS = 24;
	localparam int DIM_BITS   = 13;
	localparam int CAP_BITS   = INDEX_BITS + 1;      // saturating stride width
	localparam int PROD_BITS  = CAP_BITS + DIM_BITS;
	localparam int AXIS_LIM   = (MAX_AXES < HW_AXES) ? MAX_AXES : HW_AXES;
	localparam int CNT_BITS   = 3;
	localparam int ORD_BITS   = 8;
	localparam int SEL_BITS   = 2;

	// register indexes
	localparam logic [2:0] REG_AXIS_COUNT = 3'd0;
	localparam logic [2:0] REG_AXIS_ORDER = 3'd1;
	localparam logic [2:0] REG_DIM_ZERO   = 3'd2;
	localparam logic [2:0] REG_DIM_ONE    = 3'd3;
	localparam logic [2:0] REG_DIM_TWO    = 3'd4;
	localparam logic [2:0] REG_DIM_THREE  = 3'd5;

	localparam logic [CAP_BITS-1:0] CAP_MAX = CAP_BITS'(1) << INDEX_BITS;

	// pipeline layout: delay stages, range check, then per axis
	// DIM_BITS divide steps, one multiply step, one accumulate step
	localparam int RANGE_STG = 6;
	localparam int AXIS_STGS = DIM_BITS + 2;
	localparam int NSTG      = RANGE_STG + 1 + HW_AXES * AXIS_STGS;

	typedef struct packed {
		logic                  vld;
		logic                  ok;
		logic [INDEX_BITS-1:0] rem;
		logic [DIM_BITS-1:0]   quo;
		logic [CAP_BITS-1:0]   prod;
		logic [CAP_BITS-1:0]   acc;
	} item_t;

	function automatic logic [CAP_BITS-1:0] sat_cap(input logic [PROD_BITS-1:0] p);
		if (p >= PROD_BITS'(CAP_MAX))
			return CAP_MAX;
		return p[CAP_BITS-1:0];
	endfunction
endpackage

// File: hw/rtl/tensor_permute_address_gen_unit.sv
// ----------------------------------------------------------------------------
// tensor_permute_address_gen_unit
// Output-to-input linear index mapping for an axis permutation of a tensor.
// ----------------------------------------------------------------------------
// Takes one output element index per cycle while in_ready is high and returns,
// in order, the linear index of that element in the unpermuted input tensor
// (in_range=0 and in_index=0 when the index is past the element total or the
// mapped index does not fit in 24 bits). Throughput is one transaction per
// clock while in_ready is high. The 67 pipeline stages are set by the four
// restoring dividers that retire one quotient bit per stage (13 bits per axis);
// an output register follows them. A skid register behind the output lets the
// pipeline take a new transaction while a result waits; in_ready drops only
// while the skid holds a result. Configuration writes are registered; derived
// strides settle before any transaction reaches the stage that uses them.
module tensor_permute_address_gen_unit import tpag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [DIM_BITS-1:0]   cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [INDEX_BITS-1:0] out_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [INDEX_BITS-1:0] in_index,
	output logic                  in_range
);

	// ---------------- configuration registers ----------------
	logic [CNT_BITS-1:0] cnt_q;
	logic [ORD_BITS-1:0] ord_q;
	logic [DIM_BITS-1:0] dim_q [HW_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_BITS'(4);
			ord_q <= ORD_BITS'(228);
			for (int k = 0; k < HW_AXES; k++)
				dim_q[k] <= DIM_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_COUNT: cnt_q    <= cfg_data[CNT_BITS-1:0];
				REG_AXIS_ORDER: ord_q    <= cfg_data[ORD_BITS-1:0];
				REG_DIM_ZERO:   dim_q[0] <= cfg_data;
				REG_DIM_ONE:    dim_q[1] <= cfg_data;
				REG_DIM_TWO:    dim_q[2] <= cfg_data;
				REG_DIM_THREE:  dim_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- derived configuration ----------------
	// Level 2: effective input/output dims and axis selects.
	logic [CNT_BITS-1:0] nax;
	logic [DIM_BITS-1:0] ed_c [HW_AXES];
	logic [DIM_BITS-1:0] ed_q [HW_AXES];
	logic [DIM_BITS-1:0] od_q [HW_AXES];
	logic [SEL_BITS-1:0] sel_q [HW_AXES];

	always_comb begin
		if (cnt_q == '0)
			nax = CNT_BITS'(1);
		else if (cnt_q > CNT_BITS'(AXIS_LIM))
			nax = CNT_BITS'(AXIS_LIM);
		else
			nax = cnt_q;
		for (int k = 0; k < HW_AXES; k++)
			ed_c[k] = (CNT_BITS'(k) < nax) ? dim_q[k] : DIM_BITS'(1);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < HW_AXES; k++) begin
			ed_q[k]  <= ed_c[k];
			sel_q[k] <= ord_q[SEL_BITS*k +: SEL_BITS];
			od_q[k]  <= (CNT_BITS'(k) < nax) ? ed_c[ord_q[SEL_BITS*k +: SEL_BITS]]
				: DIM_BITS'(1);
		end
	end

	// Levels 3-5: saturating stride products, element total, stride selects.
	logic [CAP_BITS-1:0] is2_q, is1_q, is0_q, os2_q, os1_q, os0_q, tot_q;
	logic [CAP_BITS-1:0] istr_v [HW_AXES];
	logic [CAP_BITS-1:0] ostr_v [HW_AXES];
	logic [CAP_BITS-1:0] isel_q [HW_AXES];

	always_ff @(posedge clk) begin
		is2_q <= CAP_BITS'(ed_q[3]);
		os2_q <= CAP_BITS'(od_q[3]);
		is1_q <= sat_cap(PROD_BITS'(ed_q[2]) * PROD_BITS'(ed_q[3]));
		os1_q <= sat_cap(PROD_BITS'(od_q[2]) * PROD_BITS'(od_q[3]));
		is0_q <= sat_cap(PROD_BITS'(is1_q) * PROD_BITS'(ed_q[1]));
		os0_q <= sat_cap(PROD_BITS'(os1_q) * PROD_BITS'(od_q[1]));
		tot_q <= sat_cap(PROD_BITS'(os0_q) * PROD_BITS'(od_q[0]));
		for (int k = 0; k < HW_AXES; k++)
			isel_q[k] <= istr_v[sel_q[k]];
	end

	assign istr_v[0] = is0_q;
	assign istr_v[1] = is1_q;
	assign istr_v[2] = is2_q;
	assign istr_v[3] = CAP_BITS'(1);
	assign ostr_v[0] = os0_q;
	assign ostr_v[1] = os1_q;
	assign ostr_v[2] = os2_q;
	assign ostr_v[3] = CAP_BITS'(1);

	// ---------------- item pipeline ----------------
	logic  en;
	logic  out_vld_q, skid_vld_q;
	item_t pipe_s [NSTG];
	item_t nxt    [NSTG];

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_comb begin
		nxt[0]     = '0;
		nxt[0].vld = in_valid;
		nxt[0].rem = out_index;
	end

	for (genvar i = 1; i < NSTG; i++) begin : g_stg
		if (i < RANGE_STG) begin : g_dly
			assign nxt[i] = pipe_s[i-1];
		end else if (i == RANGE_STG) begin : g_rng
			always_comb begin
				nxt[i]      = pipe_s[i-1];
				nxt[i].ok   = CAP_BITS'(pipe_s[i-1].rem) < tot_q;
				nxt[i].acc  = '0;
				nxt[i].prod = '0;
			end
		end else begin : g_axis
			localparam int K = (i - RANGE_STG - 1) / AXIS_STGS;
			localparam int T = (i - RANGE_STG - 1) % AXIS_STGS;
			if (T < DIM_BITS) begin : g_div
				// restoring divide step, quotient bit DIM_BITS-1-T
				logic [PROD_BITS-1:0] dd;
				logic                 ge;
				assign dd = PROD_BITS'(ostr_v[K]) << (DIM_BITS - 1 - T);
				assign ge = PROD_BITS'(pipe_s[i-1].rem) >= dd;
				always_comb begin
					nxt[i]     = pipe_s[i-1];
					nxt[i].quo = {pipe_s[i-1].quo[DIM_BITS-2:0], ge};
					if (ge)
						nxt[i].rem = pipe_s[i-1].rem - dd[INDEX_BITS-1:0];
				end
			end else if (T == DIM_BITS) begin : g_mul
				always_comb begin
					nxt[i]      = pipe_s[i-1];
					nxt[i].prod = sat_cap(PROD_BITS'(pipe_s[i-1].quo) *
						PROD_BITS'(isel_q[K]));
				end
			end else begin : g_add
				logic [CAP_BITS:0] sum;
				assign sum = {1'b0, pipe_s[i-1].acc} + {1'b0, pipe_s[i-1].prod};
				always_comb begin
					nxt[i]     = pipe_s[i-1];
					nxt[i].acc = (sum >= (CAP_BITS+1)'(CAP_MAX)) ? CAP_MAX
						: sum[CAP_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++)
				pipe_s[i].vld <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < NSTG; i++)
				pipe_s[i] <= nxt[i];
		end
	end

	// ---------------- output register and skid ----------------
	logic                  last_vld;
	logic                  res_rng;
	logic [INDEX_BITS-1:0] res_idx;
	logic                  skid_rng_q, out_rng_q;
	logic [INDEX_BITS-1:0] skid_idx_q, out_idx_q;
	logic                  to_skid;

	assign last_vld = pipe_s[NSTG-1].vld;
	assign res_rng  = pipe_s[NSTG-1].ok && !pipe_s[NSTG-1].acc[INDEX_BITS];
	assign res_idx  = res_rng ? pipe_s[NSTG-1].acc[INDEX_BITS-1:0] : '0;
	assign to_skid  = out_vld_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			// output slot refills from the skid or from the pipeline when taken
			if (out_vld_q && out_ready)
				out_vld_q <= skid_vld_q || (en && last_vld);
			else if (en && last_vld)
				out_vld_q <= 1'b1;
			if (en && last_vld && to_skid)
				skid_vld_q <= 1'b1;
			else if (out_vld_q && out_ready)
				skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && out_ready && skid_vld_q) begin
			out_idx_q <= skid_idx_q;
			out_rng_q <= skid_rng_q;
		end
		if (en && last_vld) begin
			if (to_skid) begin
				skid_idx_q <= res_idx;
				skid_rng_q <= res_rng;
			end else begin
				out_idx_q <= res_idx;
				out_rng_q <= res_rng;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign in_index  = out_idx_q;
	assign in_range  = out_rng_q;

`include "assert_macros.svh"
	// a held skid result implies the output register is occupied
	`ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q)
	// out-of-range results carry a zero index
	`ASSERT_IMP(a_zero_when_oor, out_vld_q && !in_range, in_index == '0)
	// a blocked output with a new result arriving fills the skid
	`ASSERT_NXT(a_skid_fill, en && last_vld && out_vld_q && !out_ready, skid_vld_q)
	// draining the skid keeps a result on the output
	`ASSERT_NXT(a_skid_drain, skid_vld_q && out_ready, out_vld_q)

endmodule
